// File: hw/rtl/spi_mfd_pkg.sv
// -----------------------------------------------------------------------------
// SPI master package
// Shared types and codes for the full-duplex SPI master core.
// -----------------------------------------------------------------------------
package spi_mfd_pkg;

   localparam int LENGTH_BITS_DEF = 16;
   localparam int DIV_BITS        = 7;
   localparam int INDEX_BITS      = 3;

   typedef enum logic [INDEX_BITS-1:0] {
      REG_SPI_MODE     = 3'd0,
      REG_BAUD_CODE    = 3'd1,
      REG_WRITE_LENGTH = 3'd2,
      REG_READ_LENGTH  = 3'd3,
      REG_CS_GAP       = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_LEAD  = 4'b0010,
      PH_XFER  = 4'b0100,
      PH_TRAIL = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       cpol;
      logic       cpha;
      logic [2:0] baud;
   } mode_cfg_type;

endpackage

// File: hw/rtl/spi_mfd_csr.sv
// -----------------------------------------------------------------------------
// SPI master control registers
// Decodes register writes and holds mode, clock divider, lengths and gap.
// -----------------------------------------------------------------------------
module spi_mfd_csr #(
   parameter int LENGTH_BITS = spi_mfd_pkg::LENGTH_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [spi_mfd_pkg::INDEX_BITS-1:0]  csr_index,
   input  logic [LENGTH_BITS-1:0]              csr_wdata,
   output spi_mfd_pkg::mode_cfg_type           mode_cfg,
   output logic [LENGTH_BITS-1:0]              write_len,
   output logic [LENGTH_BITS-1:0]              read_len,
   output logic [LENGTH_BITS-1:0]              gap_len
);

   spi_mfd_pkg::mode_cfg_type mode_ff;
   logic [LENGTH_BITS-1:0]    wlen_ff;
   logic [LENGTH_BITS-1:0]    rlen_ff;
   logic [LENGTH_BITS-1:0]    gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff.cpol <= 1'b0;
         mode_ff.cpha <= 1'b0;
         mode_ff.baud <= 3'd7;
         wlen_ff      <= '0;
         rlen_ff      <= '0;
         gap_ff       <= '0;
      end else if (csr_we) begin
         case (csr_index)
            spi_mfd_pkg::REG_SPI_MODE: begin
               mode_ff.cpol <= csr_wdata[1];
               mode_ff.cpha <= csr_wdata[0];
            end
            spi_mfd_pkg::REG_BAUD_CODE: begin
               mode_ff.baud <= csr_wdata[2:0];
            end
            spi_mfd_pkg::REG_WRITE_LENGTH: begin
               wlen_ff <= csr_wdata;
            end
            spi_mfd_pkg::REG_READ_LENGTH: begin
               rlen_ff <= csr_wdata;
            end
            spi_mfd_pkg::REG_CS_GAP: begin
               gap_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign mode_cfg  = mode_ff;
   assign write_len = wlen_ff;
   assign read_len  = rlen_ff;
   assign gap_len   = gap_ff;

endmodule

// File: hw/rtl/spi_master_full_duplex_core.sv
// -----------------------------------------------------------------------------
// SPI master, full duplex, 8-bit, modes 0 to 3
// One request transaction is one system tick: start, next transmit byte and
// the MISO level. Every request yields exactly one response transaction with
// chip select, SCLK, MOSI, the transmit-byte-taken flag, a received byte with
// its valid flag, busy and done.
// The response for a request is presented on the cycle after the request is
// accepted. Throughput: one request per cycle while responses are taken;
// the tick state is updated by one registered pass of the control logic.
// The response channel has one output register; req_ready stays high while
// that register is empty or being drained, so a stalled receiver holds the
// request side after one pending response, and no tick is lost or repeated.
// Serial timing counts request transactions, not clock cycles.
// Reset: synchronous; the phase goes idle, SCLK state at polarity 0, divider
// 2^8 ticks per period, lengths and gap zero; outputs are not reset. The user
// writes registers via the csr_ port, no handshake, only while idle, unenforced.
// -----------------------------------------------------------------------------
module spi_master_full_duplex_core #(
   parameter int LENGTH_BITS = spi_mfd_pkg::LENGTH_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_start_req,
   input  logic [7:0]                          req_tx_byte,
   input  logic                                req_miso,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_cs_n,
   output logic                                rsp_sclk,
   output logic                                rsp_mosi,
   output logic                                rsp_tx_taken,
   output logic                                rsp_rx_valid,
   output logic [7:0]                          rsp_rx_byte,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   input  logic                                csr_we,
   input  logic [spi_mfd_pkg::INDEX_BITS-1:0]  csr_index,
   input  logic [LENGTH_BITS-1:0]              csr_wdata
);

   spi_mfd_pkg::mode_cfg_type mode_cfg;
   logic [LENGTH_BITS-1:0]    write_len;
   logic [LENGTH_BITS-1:0]    read_len;
   logic [LENGTH_BITS-1:0]    gap_len;

   spi_mfd_csr #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mode_cfg  (mode_cfg),
      .write_len (write_len),
      .read_len  (read_len),
      .gap_len   (gap_len)
   );

   spi_mfd_pkg::phase_type               phase_ff, phase_in;
   logic [spi_mfd_pkg::DIV_BITS-1:0]     div_ff, div_in;
   logic [2:0]                           bit_ff, bit_in;
   logic [LENGTH_BITS-1:0]               byte_ff, byte_in;
   logic [LENGTH_BITS-1:0]               gap_ff, gap_in;
   logic [7:0]                           tx_ff, tx_in;
   logic [7:0]                           rx_ff, rx_in;
   logic                                 clk_ff, clk_in;

   logic                                 rsp_valid_ff;
   logic                                 cs_n_ff, sclk_ff, mosi_ff, taken_ff;
   logic                                 rxv_ff, busy_ff, done_ff;
   logic [7:0]                           rxb_ff;

   logic                                 accept;
   logic                                 taken, rxv, done;
   logic [7:0]                           rxb;
   logic [spi_mfd_pkg::DIV_BITS:0]       half;
   logic [spi_mfd_pkg::DIV_BITS:0]       div_inc;
   logic [LENGTH_BITS:0]                 gap_inc;
   logic [LENGTH_BITS:0]                 byte_inc;
   logic [LENGTH_BITS-1:0]               total_raw;
   logic [LENGTH_BITS-1:0]               total;
   logic                                 leading;
   logic                                 mode_wr;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign mode_wr   = csr_we && (csr_index == spi_mfd_pkg::REG_SPI_MODE);

   assign half      = (spi_mfd_pkg::DIV_BITS+1)'(1) << mode_cfg.baud;
   assign div_inc   = {1'b0, div_ff} + (spi_mfd_pkg::DIV_BITS+1)'(1);
   assign gap_inc   = {1'b0, gap_ff} + (LENGTH_BITS+1)'(1);
   assign byte_inc  = {1'b0, byte_ff} + (LENGTH_BITS+1)'(1);
   assign total_raw = (write_len > read_len) ? write_len : read_len;
   assign total     = (total_raw == '0) ? LENGTH_BITS'(1) : total_raw;
   assign leading   = (clk_ff == mode_cfg.cpol);

   always_comb begin
      phase_in = phase_ff;
      div_in   = div_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      gap_in   = gap_ff;
      tx_in    = tx_ff;
      rx_in    = rx_ff;
      clk_in   = clk_ff;
      taken    = 1'b0;
      rxv      = 1'b0;
      rxb      = 8'd0;
      done     = 1'b0;
      case (phase_ff)
         spi_mfd_pkg::PH_IDLE: begin
            clk_in = mode_cfg.cpol;
            if (req_start_req) begin
               byte_in = '0;
               bit_in  = '0;
               div_in  = '0;
               gap_in  = '0;
               rx_in   = 8'd0;
               if (write_len != '0) begin
                  tx_in = req_tx_byte;
                  taken = 1'b1;
               end else begin
                  tx_in = 8'd0;
               end
               phase_in = (gap_len == '0) ? spi_mfd_pkg::PH_XFER : spi_mfd_pkg::PH_LEAD;
            end
         end
         spi_mfd_pkg::PH_LEAD: begin
            gap_in = gap_inc[LENGTH_BITS-1:0];
            if (gap_inc >= {1'b0, gap_len}) begin
               phase_in = spi_mfd_pkg::PH_XFER;
               div_in   = '0;
               gap_in   = '0;
            end
         end
         spi_mfd_pkg::PH_XFER: begin
            if (div_inc >= half) begin
               div_in = '0;
               clk_in = !clk_ff;
               if (leading) begin
                  if (!mode_cfg.cpha) begin
                     rx_in = {rx_ff[6:0], req_miso};
                  end else if (bit_ff != 3'd0) begin
                     tx_in = {tx_ff[6:0], 1'b0};
                  end else if (byte_ff != '0) begin
                     if (byte_ff < write_len) begin
                        tx_in = req_tx_byte;
                        taken = 1'b1;
                     end else begin
                        tx_in = 8'd0;
                     end
                  end
               end else begin
                  if (mode_cfg.cpha) begin
                     rx_in = {rx_ff[6:0], req_miso};
                  end
                  if (bit_ff == 3'd7) begin
                     if (byte_ff < read_len) begin
                        rxv = 1'b1;
                        rxb = rx_in;
                     end
                     bit_in = '0;
                     if (byte_inc >= {1'b0, total}) begin
                        gap_in = '0;
                        if (gap_len == '0) begin
                           phase_in = spi_mfd_pkg::PH_IDLE;
                           done     = 1'b1;
                        end else begin
                           phase_in = spi_mfd_pkg::PH_TRAIL;
                        end
                     end else begin
                        byte_in = byte_inc[LENGTH_BITS-1:0];
                        if (!mode_cfg.cpha) begin
                           if (byte_inc < {1'b0, write_len}) begin
                              tx_in = req_tx_byte;
                              taken = 1'b1;
                           end else begin
                              tx_in = 8'd0;
                           end
                        end
                     end
                  end else begin
                     bit_in = bit_ff + 3'd1;
                     if (!mode_cfg.cpha) begin
                        tx_in = {tx_ff[6:0], 1'b0};
                     end
                  end
               end
            end else begin
               div_in = div_inc[spi_mfd_pkg::DIV_BITS-1:0];
            end
         end
         spi_mfd_pkg::PH_TRAIL: begin
            gap_in = gap_inc[LENGTH_BITS-1:0];
            if (gap_inc >= {1'b0, gap_len}) begin
               phase_in = spi_mfd_pkg::PH_IDLE;
               gap_in   = '0;
               done     = 1'b1;
               clk_in   = mode_cfg.cpol;
            end
         end
         default: begin
            phase_in = spi_mfd_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spi_mfd_pkg::PH_IDLE;
         div_ff   <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         gap_ff   <= '0;
         tx_ff    <= 8'd0;
         rx_ff    <= 8'd0;
         clk_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         div_ff   <= div_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         gap_ff   <= gap_in;
         tx_ff    <= tx_in;
         rx_ff    <= rx_in;
         clk_ff   <= clk_in;
      end else if (mode_wr && (phase_ff == spi_mfd_pkg::PH_IDLE)) begin
         clk_ff <= csr_wdata[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cs_n_ff  <= (phase_in == spi_mfd_pkg::PH_IDLE);
         busy_ff  <= (phase_in != spi_mfd_pkg::PH_IDLE);
         sclk_ff  <= clk_in;
         mosi_ff  <= tx_in[7];
         taken_ff <= taken;
         rxv_ff   <= rxv;
         rxb_ff   <= rxb;
         done_ff  <= done;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cs_n     = cs_n_ff;
   assign rsp_sclk     = sclk_ff;
   assign rsp_mosi     = mosi_ff;
   assign rsp_tx_taken = taken_ff;
   assign rsp_rx_valid = rxv_ff;
   assign rsp_rx_byte  = rxb_ff;
   assign rsp_busy_res = busy_ff;
   assign rsp_done_res = done_ff;

`ifndef SYNTHESIS
   a_cs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cs_n != rsp_busy_res))
      else $error("chip select disagrees with busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_res) |-> rsp_cs_n)
      else $error("done reported while chip select low");

   a_rx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_rx_valid) |-> (rsp_rx_byte == 8'd0))
      else $error("received byte not cleared without valid");

   a_bit_xfer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != spi_mfd_pkg::PH_XFER) |-> (bit_ff == 3'd0))
      else $error("bit counter running outside transfer");

   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");
`endif

endmodule
